// ----- sv/fpr_pkg.sv -----
package fpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int NUM_W      = 5;
  localparam int TOTAL_W    = 32;
  localparam logic [NUM_W-1:0] NUM_FRAMES_RST = NUM_W'(3);

  typedef struct packed {
    logic hit;
    logic empty;
  } fpr_chain_t;

endpackage

// ----- sv/fpr_cell.sv -----
module fpr_cell
  import fpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 active,
  input  logic [PAGE_BITS-1:0] page,
  input  logic                 wr_en,
  input  fpr_chain_t           chain_i,
  output fpr_chain_t           chain_o,
  output logic                 first_hit,
  output logic                 first_empty,
  output logic [PAGE_BITS-1:0] page_q
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic                 match;
  logic                 empty;

  assign match       = active && valid_r && (page_r == page);
  assign empty       = active && !valid_r;
  assign first_hit   = match && !chain_i.hit;
  assign first_empty = empty && !chain_i.empty;
  assign chain_o.hit   = chain_i.hit || match;
  assign chain_o.empty = chain_i.empty || empty;
  assign page_q      = page_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r <= page;
    end
  end

endmodule

// ----- sv/fifo_page_replacement.sv -----
// FIFO page replacement engine.
// Input channel in_valid/in_ready carries one page reference per request.
// Result channel out_valid/out_ready returns one result per request: fault
// flag, slot now holding the page, evicted page (if any) and the running
// saturating fault count.
// cfg_wr_en/cfg_wr_data write num_frames (0 acts as 1, above 16 acts as 16);
// write it only while no request is in flight.
// Flow: a request is accepted into the single shared request register
// ahead of the frame cells; the frame chain is searched and updated once
// the result register is free, and the result is registered at that edge.
// in_ready drops after each accept and stays low until that result is
// registered, so a new request is not taken before the last one is done.
// Search is done by a chain of frame cells, each comparing its page and
// passing hit/empty priority to its neighbor.
// Reset (synchronous, rst_n low) empties all frames, clears the replace
// pointer and fault count, and sets num_frames to 3.
// When out_ready is low the result holds; a pending request waits in its
// register and in_ready stays low until the result is taken.
module fifo_page_replacement
  import fpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_page_fault,
  output logic [SLOT_W-1:0]    out_frame_slot,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [TOTAL_W-1:0]   out_fault_total,
  input  logic                 cfg_wr_en,
  input  logic [NUM_W-1:0]     cfg_wr_data
);

  logic [NUM_W-1:0]     num_frames_r;
  logic                 busy_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [SLOT_W-1:0]    ptr_r, ptr_nxt;
  logic [TOTAL_W-1:0]   fault_cnt_r, fault_cnt_nxt;

  logic                 out_valid_r;
  logic                 out_fault_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_valid_r;
  logic [PAGE_BITS-1:0] out_ev_page_r;

  logic                 fire;
  logic [CNT_W-1:0]     n_act;
  logic [MAX_FRAMES-1:0] active;
  logic [MAX_FRAMES-1:0] hit_oh;
  logic [MAX_FRAMES-1:0] empty_oh;
  logic [MAX_FRAMES-1:0] wr_en;
  fpr_chain_t           chain [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] page_q [MAX_FRAMES];

  logic                 hit;
  logic                 have_empty;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    empty_slot;
  logic [SLOT_W-1:0]    victim;
  logic [SLOT_W-1:0]    slot_sel;
  logic [PAGE_BITS-1:0] victim_page;

  assign in_ready = !busy_r;
  assign fire     = busy_r && (!out_valid_r || out_ready);

  always_comb begin
    if (num_frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(num_frames_r) > MAX_FRAMES) begin
      n_act = CNT_W'(MAX_FRAMES);
    end else begin
      n_act = CNT_W'(num_frames_r);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign active[i] = 32'(i) < 32'(n_act);
    assign wr_en[i]  = fire && !hit && (slot_sel == SLOT_W'(i));

    fpr_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .active      (active[i]),
      .page        (page_r),
      .wr_en       (wr_en[i]),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .first_hit   (hit_oh[i]),
      .first_empty (empty_oh[i]),
      .page_q      (page_q[i])
    );
  end

  assign hit        = chain[MAX_FRAMES].hit;
  assign have_empty = chain[MAX_FRAMES].empty;
  assign victim     = (32'(ptr_r) < 32'(n_act)) ? ptr_r : '0;

  always_comb begin
    hit_slot    = '0;
    empty_slot  = '0;
    victim_page = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      hit_slot   = hit_slot | (hit_oh[i] ? SLOT_W'(i) : '0);
      empty_slot = empty_slot | (empty_oh[i] ? SLOT_W'(i) : '0);
      victim_page = victim_page | ((victim == SLOT_W'(i)) ? page_q[i] : '0);
    end
  end

  always_comb begin
    if (hit) begin
      slot_sel = hit_slot;
    end else if (have_empty) begin
      slot_sel = empty_slot;
    end else begin
      slot_sel = victim;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (fire && !hit && !have_empty) begin
      if (32'(victim) + 1 >= 32'(n_act)) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = victim + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (fire && !hit && (fault_cnt_r != '1)) begin
      fault_cnt_nxt = fault_cnt_r + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= NUM_FRAMES_RST;
      busy_r       <= 1'b0;
      ptr_r        <= '0;
      fault_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        num_frames_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      ptr_r       <= ptr_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      page_r <= in_page_number;
    end
    if (fire) begin
      out_fault_r    <= !hit;
      out_slot_r     <= slot_sel;
      out_ev_valid_r <= !hit && !have_empty;
      out_ev_page_r  <= (!hit && !have_empty) ? victim_page : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_page_fault    = out_fault_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = fault_cnt_r;

endmodule

// ----- sv/fpr_checker.sv -----
module fpr_checker
  import fpr_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_page_fault,
  input logic [SLOT_W-1:0]    out_frame_slot,
  input logic                 out_evicted_valid,
  input logic [PAGE_BITS-1:0] out_evicted_page,
  input logic [TOTAL_W-1:0]   out_fault_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_slot)
      && $stable(out_fault_total) && $stable(out_evicted_page))
    else $error("result changed while stalled");

  // eviction implies a fault; no eviction means zero page
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_evicted_valid || out_page_fault)
      && (out_evicted_valid || (out_evicted_page == '0)))
    else $error("bad eviction fields");

  // one request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted too early");

  // a result with a fault carries a nonzero count
  a_fault_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_fault |-> out_fault_total != '0)
    else $error("fault count zero on fault");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (.*);

// ----- verif/tb_fifo_page_replacement.sv -----
`timescale 1ns / 100ps

module tb_fifo_page_replacement;
  import fpr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam int BLOCK_ITEMS  = 118;
  localparam int BLOCKS       = 4;

  typedef struct packed {
    logic                 fault;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [TOTAL_W-1:0]   total;
  } page_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PAGE_BITS-1:0] in_page_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_page_fault;
  logic [SLOT_W-1:0]    out_frame_slot;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [TOTAL_W-1:0]   out_fault_total;
  logic                 cfg_wr_en = 1'b0;
  logic [NUM_W-1:0]     cfg_wr_data = '0;

  // predictor state
  logic [PAGE_BITS-1:0] resident_page [MAX_FRAMES];
  logic                 resident_valid [MAX_FRAMES];
  logic [SLOT_W-1:0]    rr_pointer;
  logic [TOTAL_W-1:0]   faults_so_far;
  logic [NUM_W-1:0]     frame_count_reg;

  page_result_t pending_results[$];
  int           mismatches = 0;
  int           cycles = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;

  fifo_page_replacement dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_page_fault   (out_page_fault),
    .out_frame_slot   (out_frame_slot),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_fault_total  (out_fault_total),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycles,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int active_frames();
    if (frame_count_reg == 0) return 1;
    if (frame_count_reg > MAX_FRAMES) return MAX_FRAMES;
    return int'(frame_count_reg);
  endfunction

  function automatic void resolve_page(input logic [PAGE_BITS-1:0] page);
    page_result_t r;
    int n;
    int slot;
    int empty_slot;
    bit hit;
    bit have_empty;
    n = active_frames();
    slot = 0;
    empty_slot = 0;
    hit = 0;
    have_empty = 0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (resident_valid[i] && resident_page[i] == page && !hit) begin
        hit = 1;
        slot = i;
      end
      if (!resident_valid[i] && !have_empty) begin
        have_empty = 1;
        empty_slot = i;
      end
    end
    if (!hit) begin
      r.fault = 1'b1;
      if (faults_so_far != '1) faults_so_far = faults_so_far + TOTAL_W'(1);
      if (have_empty) begin
        slot = empty_slot;
      end else begin
        slot = (rr_pointer < n) ? int'(rr_pointer) : 0;
        r.ev_valid = 1'b1;
        r.ev_page = resident_page[slot];
        rr_pointer = (slot + 1 >= n) ? '0 : SLOT_W'(slot + 1);
      end
      resident_page[slot] = page;
      resident_valid[slot] = 1'b1;
    end
    r.slot = SLOT_W'(slot);
    r.total = faults_so_far;
    pending_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_page_fault, out_frame_slot, out_evicted_valid, out_evicted_page,
              out_fault_total};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: fault=%0b slot=%0d ev=%0b/%h total=%0d",
                   got.fault, got.slot, got.ev_valid, got.ev_page, got.total);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch: exp fault=%0b slot=%0d ev=%0b/%h total=%0d, ",
                      "got fault=%0b slot=%0d ev=%0b/%h total=%0d"},
                     want.fault, want.slot, want.ev_valid, want.ev_page, want.total,
                     got.fault, got.slot, got.ev_valid, got.ev_page, got.total);
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_page(input logic [PAGE_BITS-1:0] page);
    in_valid = 1'b1;
    in_page_number = page;
    do @(posedge clk); while (!in_ready);
    resolve_page(page);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      in_page_number = PAGE_BITS'($urandom);
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_frame_count(input logic [NUM_W-1:0] value);
    wait_idle();
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cfg_wr_data = NUM_W'($urandom);
    frame_count_reg = value;
  endtask

  task automatic test_fill_and_evict();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h1234);
    send_page(16'hFFFF);
    send_page(16'h8001);
  endtask

  // zero acts as one frame; pointer left at 1 is out of range
  task automatic test_zero_frames();
    write_frame_count(NUM_W'(0));
    send_page(16'h5555);
  endtask

  // shrinking keeps upper slots, growing brings them back; duplicate pages
  task automatic test_resize_and_duplicates();
    write_frame_count(NUM_W'(2));
    send_page(16'hFFFF);
    write_frame_count(NUM_W'(1));
    send_page(16'hFFFF);
    write_frame_count(NUM_W'(2));
    send_page(16'hFFFF);
  endtask

  task automatic test_oversize_frames();
    write_frame_count(NUM_W'(31));
    send_page(16'h1234);
    send_page(16'h0F0F);
    send_page(16'hF0F0);
    write_frame_count(NUM_W'(17));
    send_page(16'h1234);
    write_frame_count(NUM_W'(16));
    send_page(16'hAAAA);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
    logic [PAGE_BITS-1:0] pool[$];
    logic [NUM_W-1:0] count;
    int n;
    int pick;
    wait_idle();
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    for (int b = 0; b < BLOCKS; b++) begin
      pick = $urandom_range(9);
      if (pick == 0) count = '0;
      else if (pick == 1) count = NUM_W'($urandom_range(31, 17));
      else count = NUM_W'($urandom_range(16, 1));
      write_frame_count(count);
      n = active_frames();
      pool.delete();
      repeat (n + $urandom_range(n + 2)) pool.push_back(PAGE_BITS'($urandom));
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        if ($urandom_range(9) == 0) send_page(PAGE_BITS'($urandom));
        else send_page(pool[$urandom_range(pool.size() - 1)]);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      resident_page[i] = '0;
      resident_valid[i] = 1'b0;
    end
    rr_pointer = '0;
    faults_so_far = '0;
    frame_count_reg = NUM_FRAMES_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_fill_and_evict();
    test_zero_frames();
    test_resize_and_duplicates();
    test_oversize_frames();
    test_random_traffic(0, 0);
    test_random_traffic(80, 0);
    test_random_traffic(0, 80);
    test_random_traffic(25, 25);

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
